// ----- sv/tht_pkg.sv -----
`timescale 1ns / 1ps

package tht_pkg;

	localparam int SLOTS        = 1024;
	localparam int KIND_WIDTH   = 8;
	localparam int OBJECT_WIDTH = 48;

	localparam int IDX_W  = $clog2(SLOTS);
	// counts and handles run from 0 to SLOTS inclusive
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [KIND_WIDTH-1:0]   kind_t;
	typedef logic [OBJECT_WIDTH-1:0] obj_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE  = 2'd0,
		CMD_ACQUIRE = 2'd1,
		CMD_RETIRE  = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_NULL = 2'd1,
		STATUS_FULL = 2'd2,
		STATUS_BAD  = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		logic  alive;
		kind_t kind;
		obj_t  obj;
	} slot_entry_t;

	localparam int SLOT_W = $bits(slot_entry_t);

	typedef struct packed {
		logic        re;
		idx_t        raddr;
		logic        we;
		idx_t        waddr;
		slot_entry_t wdata;
	} slot_req_t;

	typedef struct packed {
		logic re;
		idx_t raddr;
		logic we;
		idx_t waddr;
		idx_t wdata;
	} free_req_t;

endpackage

// ----- sv/tht_ram.sv -----
`timescale 1ns / 1ps

module tht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/tht_engine.sv -----
`timescale 1ns / 1ps

module tht_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [tht_pkg::CMD_W-1:0]    cmd,
	input  tht_pkg::cnt_t                handle,
	input  tht_pkg::kind_t               kind,
	input  tht_pkg::obj_t                object_ref,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output tht_pkg::cnt_t                new_handle,
	output tht_pkg::obj_t                found_object,
	output logic [tht_pkg::STAT_W-1:0]   status,
	output tht_pkg::slot_req_t           slot_req,
	input  tht_pkg::slot_entry_t         slot_rdata,
	output tht_pkg::free_req_t           free_req,
	input  tht_pkg::idx_t                free_rdata
);

	import tht_pkg::*;

	fsm_t    state_q, state_d;
	cnt_t    used_q, used_d;
	cnt_t    free_depth_q, free_depth_d;
	logic    rsp_valid_q, rsp_valid_d;
	cnt_t    new_handle_q, new_handle_d;
	obj_t    found_object_q, found_object_d;
	status_t status_q, status_d;

	cmd_t    cmd_s1;
	cnt_t    handle_s1;
	kind_t   kind_s1;
	obj_t    obj_s1;

	logic    accept;
	logic    exec_fire;
	logic    hit;
	cnt_t    hidx_full;
	cnt_t    depth_m1;
	idx_t    handle_m1;
	idx_t    new_idx;

	assign req_ready = (state_q == FSM_IDLE);
	assign accept    = req_valid && req_ready;
	// advance out of EXEC only when the output register can take the beat
	assign exec_fire = (state_q == FSM_EXEC) && (!rsp_valid_q || rsp_ready);

	assign handle_m1 = handle[IDX_W-1:0] - IDX_W'(1);
	assign depth_m1  = free_depth_q - CNT_W'(1);
	assign hidx_full = handle_s1 - CNT_W'(1);
	assign hit = (handle_s1 != '0) && (hidx_full < used_q) &&
	             slot_rdata.alive && (slot_rdata.kind == kind_s1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (exec_fire) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		slot_req       = '0;
		free_req       = '0;
		used_d         = used_q;
		free_depth_d   = free_depth_q;
		new_handle_d   = new_handle_q;
		found_object_d = found_object_q;
		status_d       = status_q;
		rsp_valid_d    = rsp_valid_q && !rsp_ready;
		new_idx        = '0;

		// launch both reads with the accepted beat
		slot_req.re    = accept;
		slot_req.raddr = handle_m1;
		free_req.re    = accept;
		free_req.raddr = depth_m1[IDX_W-1:0];

		if (exec_fire) begin
			rsp_valid_d    = 1'b1;
			new_handle_d   = '0;
			found_object_d = '0;
			status_d       = STATUS_BAD;
			case (cmd_s1)
				CMD_CREATE: begin
					if (obj_s1 == '0) begin
						status_d = STATUS_NULL;
					end else if (free_depth_q != '0 || used_q < CNT_W'(SLOTS)) begin
						if (free_depth_q != '0) begin
							new_idx      = free_rdata;
							free_depth_d = depth_m1;
						end else begin
							new_idx = used_q[IDX_W-1:0];
							used_d  = used_q + CNT_W'(1);
						end
						slot_req.we          = 1'b1;
						slot_req.waddr       = new_idx;
						slot_req.wdata.alive = 1'b1;
						slot_req.wdata.kind  = kind_s1;
						slot_req.wdata.obj   = obj_s1;
						new_handle_d = CNT_W'(new_idx) + CNT_W'(1);
						status_d     = STATUS_OK;
					end else begin
						status_d = STATUS_FULL;
					end
				end
				CMD_ACQUIRE, CMD_RETIRE: begin
					if (hit) begin
						found_object_d = slot_rdata.obj;
						status_d       = STATUS_OK;
						if (cmd_s1 == CMD_RETIRE) begin
							slot_req.we    = 1'b1;
							slot_req.waddr = hidx_full[IDX_W-1:0];
							slot_req.wdata = '0;
							if (free_depth_q < CNT_W'(SLOTS)) begin
								free_req.we    = 1'b1;
								free_req.waddr = free_depth_q[IDX_W-1:0];
								free_req.wdata = hidx_full[IDX_W-1:0];
								free_depth_d   = free_depth_q + CNT_W'(1);
							end
						end
					end
				end
				default: status_d = STATUS_BAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			used_q       <= '0;
			free_depth_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			used_q       <= used_d;
			free_depth_q <= free_depth_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_t'(cmd);
			handle_s1 <= handle;
			kind_s1   <= kind;
			obj_s1    <= object_ref;
		end
		new_handle_q   <= new_handle_d;
		found_object_q <= found_object_d;
		status_q       <= status_d;
	end

	assign rsp_valid    = rsp_valid_q;
	assign new_handle   = new_handle_q;
	assign found_object = found_object_q;
	assign status       = status_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(SLOTS))
		else $error("used slot count beyond capacity");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_depth_q <= used_q)
		else $error("free stack deeper than used slots");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == FSM_EXEC)
		else $error("accepted beat did not enter execute");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_req.we || free_req.we) |-> (state_q == FSM_EXEC) && !accept)
		else $error("memory write outside execute or alongside a read");

	a_fail_no_obj: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != STATUS_OK) |-> found_object_q == '0
		&& new_handle_q == '0)
		else $error("failed result carries a handle or object");
`endif

endmodule

// ----- sv/typed_handle_table.sv -----
`timescale 1ns / 1ps

// Typed handle table with a free stack of retired slot indexes.
// Request channel (req_valid/req_ready): cmd, handle, kind, object_ref.
//   create stores kind and a nonzero object_ref and returns slot index + 1;
//   acquire looks a handle up; retire looks it up, then frees the slot.
// Response channel (rsp_valid/rsp_ready): new_handle, found_object, status.
// Every request gives exactly one response beat.
// The request is registered together with the slot and free-stack RAM reads, then the
//   engine checks and writes back in its execute state and registers the result.
// The block takes no new request until it has written back the last one.
// A stalled receiver holds the engine in its execute state until the
//   output register frees; the request side waits through that.
// Reset clears the used-slot count, free-stack depth, FSM state and response
//   valid flag only. No clearing pass runs: slots at or above the used count
//   were never written and are rejected by the range check before their
//   contents matter, so the block takes a request as soon as reset is released.

module typed_handle_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [tht_pkg::CMD_W-1:0]  cmd,
	input  tht_pkg::cnt_t              handle,
	input  tht_pkg::kind_t             kind,
	input  tht_pkg::obj_t              object_ref,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output tht_pkg::cnt_t              new_handle,
	output tht_pkg::obj_t              found_object,
	output logic [tht_pkg::STAT_W-1:0] status
);

	import tht_pkg::*;

	slot_req_t   slot_req;
	slot_entry_t slot_rdata;
	free_req_t   free_req;
	idx_t        free_rdata;

	// alive flag, kind and object share one word per slot
	tht_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_req.we),
		.waddr(slot_req.waddr),
		.wdata(slot_req.wdata),
		.re   (slot_req.re),
		.raddr(slot_req.raddr),
		.rdata(slot_rdata)
	);

	// free stack: only entries below the depth are ever used
	tht_ram #(
		.WIDTH(IDX_W),
		.DEPTH(SLOTS)
	) u_free_ram (
		.clk  (clk),
		.we   (free_req.we),
		.waddr(free_req.waddr),
		.wdata(free_req.wdata),
		.re   (free_req.re),
		.raddr(free_req.raddr),
		.rdata(free_rdata)
	);

	// read at the request beat, check and write back in the execute state
	tht_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.cmd         (cmd),
		.handle      (handle),
		.kind        (kind),
		.object_ref  (object_ref),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.new_handle  (new_handle),
		.found_object(found_object),
		.status      (status),
		.slot_req    (slot_req),
		.slot_rdata  (slot_rdata),
		.free_req    (free_req),
		.free_rdata  (free_rdata)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import tht_pkg::*;

	// value the command field can carry but the block does not define
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		cnt_t    new_handle;
		obj_t    found;
		status_t st;
	} handle_rsp_t;

	typedef struct {
		cnt_t  h;
		kind_t k;
	} live_entry_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             req_valid  = 1'b0;
	logic             req_ready;
	logic [CMD_W-1:0] cmd        = '0;
	cnt_t             handle     = '0;
	kind_t            kind       = '0;
	obj_t             object_ref = '0;
	logic             rsp_valid;
	logic             rsp_ready  = 1'b0;
	cnt_t             new_handle;
	obj_t             found_object;
	logic [STAT_W-1:0] status;

	typed_handle_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.cmd          (cmd),
		.handle       (handle),
		.kind         (kind),
		.object_ref   (object_ref),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.new_handle   (new_handle),
		.found_object (found_object),
		.status       (status)
	);

	always #6 clk = ~clk;

	// table mirror, updated in the order requests are accepted
	obj_t  mirror_obj  [SLOTS];
	kind_t mirror_kind [SLOTS];
	bit    mirror_live [SLOTS];
	int    mirror_used;
	int    free_idx_stack [$];

	handle_rsp_t pending_rsp [$];
	live_entry_t live_handles [$];

	bit quiet_mode     = 1'b0;
	int mismatch_count = 0;
	int sent_count     = 0;
	int reuse_count    = 0;
	int peak_used      = 0;
	int status_seen [4];
	int cycle_count    = 0;
	int ready_stall    = 0;

	// Idle length: mostly none, often short, now and then long.
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Random nonzero object reference, with the extreme values mixed in.
	function automatic obj_t pick_obj();
		obj_t v;
		case ($urandom_range(0, 15))
			0: v = obj_t'(1);
			1: v = '1;
			2: v = obj_t'(1) << (OBJECT_WIDTH - 1);
			default: v = obj_t'({$urandom, $urandom});
		endcase
		if (v == '0)
			v = obj_t'(1);
		return v;
	endfunction

	// Compute the response of one accepted request and advance the mirror.
	function automatic handle_rsp_t predict_rsp(logic [CMD_W-1:0] c, cnt_t h, kind_t k,
			obj_t o);
		handle_rsp_t r;
		int ix;
		bit hit;
		r.new_handle = '0;
		r.found      = '0;
		r.st         = STATUS_BAD;
		if (c == CMD_CREATE) begin
			if (o == '0) begin
				r.st = STATUS_NULL;
				return r;
			end
			if (free_idx_stack.size() > 0) begin
				ix = free_idx_stack.pop_back();
				reuse_count++;
			end else if (mirror_used < SLOTS) begin
				ix = mirror_used;
				mirror_used++;
				if (mirror_used > peak_used)
					peak_used = mirror_used;
			end else begin
				r.st = STATUS_FULL;
				return r;
			end
			mirror_obj[ix]  = o;
			mirror_kind[ix] = k;
			mirror_live[ix] = 1'b1;
			r.new_handle = cnt_t'(ix + 1);
			r.st         = STATUS_OK;
			return r;
		end
		if (c == CMD_ACQUIRE || c == CMD_RETIRE) begin
			ix  = int'(h) - 1;
			hit = (h != '0) && (ix < mirror_used) && mirror_live[ix] &&
				(mirror_kind[ix] == k);
			if (!hit)
				return r;
			r.found = mirror_obj[ix];
			r.st    = STATUS_OK;
			if (c == CMD_RETIRE) begin
				mirror_obj[ix]  = '0;
				mirror_kind[ix] = '0;
				mirror_live[ix] = 1'b0;
				if (free_idx_stack.size() < SLOTS)
					free_idx_stack.push_back(ix);
			end
		end
		return r;
	endfunction

	// Send one request beat, then record what it should produce.
	task automatic send_req(logic [CMD_W-1:0] c, cnt_t h, kind_t k, obj_t o);
		int gap;
		handle_rsp_t exp_rsp;
		gap = quiet_mode ? 0 : pick_idle_len();
		// drop valid only across a real gap, so back-to-back beats keep it high
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= c;
		handle     <= h;
		kind       <= k;
		object_ref <= o;
		do @(posedge clk); while (!req_ready);
		exp_rsp = predict_rsp(c, h, k, o);
		pending_rsp.push_back(exp_rsp);
		sent_count++;
		if (c == CMD_CREATE && exp_rsp.st == STATUS_OK)
			live_handles.push_back('{exp_rsp.new_handle, k});
		if (c == CMD_RETIRE && exp_rsp.st == STATUS_OK) begin
			foreach (live_handles[i]) begin
				if (live_handles[i].h == h) begin
					live_handles.delete(i);
					break;
				end
			end
		end
	endtask

	task automatic test_lookup_and_retire();
		// null object and lookups on an empty table
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(5), obj_t'(0));
		send_req(CMD_ACQUIRE, cnt_t'(0), kind_t'(0), obj_t'(0));
		send_req(CMD_ACQUIRE, cnt_t'(1), kind_t'(0), obj_t'(0));
		// three fresh slots with extreme kinds and objects
		send_req(CMD_CREATE, cnt_t'(SLOTS), kind_t'(255), '1);
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(0), obj_t'(1));
		send_req(CMD_CREATE, '1, kind_t'(8'h5a), obj_t'(48'haaaa_5555_aaaa));
		send_req(CMD_ACQUIRE, cnt_t'(1), kind_t'(255), obj_t'(0));
		send_req(CMD_ACQUIRE, cnt_t'(1), kind_t'(254), '1);
		send_req(CMD_ACQUIRE, cnt_t'(2), kind_t'(0), obj_t'(0));
		// handle past the used slots
		send_req(CMD_ACQUIRE, cnt_t'(4), kind_t'(0), obj_t'(0));
		send_req(CMD_ACQUIRE, cnt_t'(SLOTS), kind_t'(255), obj_t'(0));
		// retire, then touch the dead slot twice
		send_req(CMD_RETIRE, cnt_t'(2), kind_t'(0), obj_t'(0));
		send_req(CMD_ACQUIRE, cnt_t'(2), kind_t'(0), obj_t'(0));
		send_req(CMD_RETIRE, cnt_t'(2), kind_t'(0), obj_t'(0));
		send_req(CMD_RETIRE, cnt_t'(3), kind_t'(8'h5b), obj_t'(0));
		send_req(CMD_RETIRE, cnt_t'(1), kind_t'(255), obj_t'(0));
		// freed indexes come back last-in first-out, then a fresh slot
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(8'h11), obj_t'(48'h0000_0000_1234));
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(8'h22), obj_t'(48'h8000_0000_0000));
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(8'h33), obj_t'(48'h7fff_ffff_ffff));
		send_req(CMD_ACQUIRE, cnt_t'(1), kind_t'(8'h11), obj_t'(0));
		send_req(CMD_ACQUIRE, cnt_t'(2), kind_t'(8'h22), obj_t'(0));
		// the undefined command value
		send_req(CMD_UNUSED, cnt_t'(1), kind_t'(8'h11), '1);
		send_req(CMD_RETIRE, cnt_t'(3), kind_t'(8'h5a), obj_t'(0));
	endtask

	// Mostly well-formed traffic on live handles, with a share of noise.
	task automatic test_random_traffic(int n_items, int create_pct);
		int r;
		int pick;
		live_entry_t e;
		kind_t k;
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(0, 99);
			if (r < create_pct) begin
				send_req(CMD_CREATE, cnt_t'($urandom_range(0, SLOTS)), kind_t'($urandom),
					($urandom_range(0, 9) == 0) ? obj_t'(0) : pick_obj());
			end else if (r < 90 && live_handles.size() > 0) begin
				pick = $urandom_range(0, live_handles.size() - 1);
				e = live_handles[pick];
				k = e.k;
				if ($urandom_range(0, 99) < 15)
					k = k ^ (kind_t'(1) << $urandom_range(0, KIND_WIDTH - 1));
				send_req($urandom_range(0, 1) ? CMD_ACQUIRE : CMD_RETIRE, e.h, k,
					obj_t'({$urandom, $urandom}));
			end else begin
				send_req(CMD_W'($urandom_range(0, 3)), cnt_t'($urandom_range(0, SLOTS)),
					kind_t'($urandom), obj_t'({$urandom, $urandom}));
			end
		end
	endtask

	// Fill every slot back to back, then hit the full and null cases at capacity.
	task automatic test_table_full();
		live_entry_t e;
		quiet_mode = 1'b1;
		while (mirror_used < SLOTS || free_idx_stack.size() > 0)
			send_req(CMD_CREATE, cnt_t'($urandom_range(0, SLOTS)), kind_t'($urandom),
				pick_obj());
		quiet_mode = 1'b0;
		repeat (3)
			send_req(CMD_CREATE, cnt_t'(0), kind_t'($urandom), pick_obj());
		// null object wins over a full table
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(0), obj_t'(0));
		// last slot: handle with the top bit set
		e.h = cnt_t'(SLOTS);
		e.k = mirror_kind[SLOTS-1];
		send_req(CMD_ACQUIRE, e.h, e.k, obj_t'(0));
		send_req(CMD_RETIRE, e.h, e.k, obj_t'(0));
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(8'hc3), '1);
		send_req(CMD_ACQUIRE, e.h, kind_t'(8'hc3), obj_t'(0));
		send_req(CMD_CREATE, cnt_t'(0), kind_t'(8'h3c), pick_obj());
	endtask

	// Response side: random back-pressure unless a stall-free stretch is running.
	always @(posedge clk) begin
		if (quiet_mode) begin
			rsp_ready <= 1'b1;
		end else if (ready_stall > 0) begin
			rsp_ready <= 1'b0;
			ready_stall--;
		end else if ($urandom_range(0, 99) < 70) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_ready <= 1'b0;
			ready_stall = pick_idle_len();
		end
	end

	// Compare each response beat with the oldest prediction.
	always @(posedge clk) begin
		handle_rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			status_seen[status]++;
			if (pending_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: beat with nothing pending: handle %0d obj %h status %0d",
						$realtime, new_handle, found_object, status);
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (new_handle !== exp_rsp.new_handle || found_object !== exp_rsp.found ||
						status !== exp_rsp.st) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display({"%0t: mismatch: exp handle %0d obj %h status %0d, ",
							"got handle %0d obj %h status %0d"},
							$realtime, exp_rsp.new_handle, exp_rsp.found, exp_rsp.st,
							new_handle, found_object, status);
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses still pending",
				cycle_count, pending_rsp.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		mirror_used = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lookup_and_retire();
		test_random_traffic(100, 45);
		test_table_full();
		test_random_traffic(100, 50);

		// hold the request side idle and let every response drain
		req_valid <= 1'b0;
		while (pending_rsp.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d ok, %0d null object, %0d table full, %0d rejected",
			sent_count, status_seen[STATUS_OK], status_seen[STATUS_NULL],
			status_seen[STATUS_FULL], status_seen[STATUS_BAD]);
		$display("Peak slots used %0d, free-stack reuses %0d, mismatches %0d",
			peak_used, reuse_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
